// ----- sv/stereo_gain_clamp_level_meter_core_defines.svh -----
// Assertion helpers for the level meter core. Both expect i_clk and i_rst_n in scope.
`ifndef STEREO_GAIN_CLAMP_LEVEL_METER_CORE_DEFINES_SVH
`define STEREO_GAIN_CLAMP_LEVEL_METER_CORE_DEFINES_SVH

// Consequent checked in the same cycle.
`define SGCLM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the following cycle.
`define SGCLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sgclm_pkg.sv -----
package sgclm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int MAG_W    = 15;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int ROOT_W   = MAG_W;
    localparam int FRAMES_W = 9;
    localparam int CFG_IDX_W = 8;

    localparam logic [MAG_W-1:0]  SAT_MAX    = 15'h7FFF;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'h010000;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SECOND = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_CH   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_MIX    = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LVL,
        ST_SQR,
        ST_ACC,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_state;

endpackage

// ----- sv/stereo_gain_clamp_level_meter_core.sv -----
// Stereo gain / clamp / level meter.
// Input channel (i_in_valid / o_in_ready) takes one stereo frame per request: two raw
// samples, the source instance that picks the gain, and a last-frame flag.
// Output channel (o_out_valid / i_out_ready) returns one result per frame: the gained,
// saturated samples (or their mono mix) plus block levels on the frame that ends a block.
// Config channel (i_cfg_valid / o_cfg_ready) writes gains and mode bits; always ready,
// only to be used while the block is idle. Unknown indexes are dropped.
// From input request to result a frame passes a bit-serial gain multiply, a bit-serial
// square and bookkeeping states. A block-end frame adds a restoring divide of SUM_W
// quotient bits and a square root (load plus 15 steps).
// One frame is processed at a time; the next is taken only once the result of the
// last one is registered.
// A finished result sits in the output register; a stalled receiver does not block the
// next frame's processing, only the hand-off of its result.
// Reset clears the meter accumulators and output valid and sets both gains to 1.0.
// A block ends on last_frame or when it reaches MAX_FRAMES frames.
`include "stereo_gain_clamp_level_meter_core_defines.svh"

module stereo_gain_clamp_level_meter_core #(
    parameter int MAX_FRAMES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [sgclm_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [sgclm_pkg::SAMPLE_W-1:0] i_right_sample,
    input  logic                                i_instance_req,
    input  logic                                i_last_frame,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [sgclm_pkg::SAMPLE_W-1:0] o_out_left,
    output logic signed [sgclm_pkg::SAMPLE_W-1:0] o_out_right,
    output logic                                o_level_valid,
    output logic [sgclm_pkg::MAG_W-1:0]         o_peak_level,
    output logic [sgclm_pkg::ROOT_W-1:0]        o_rms_level,
    output logic [sgclm_pkg::FRAMES_W-1:0]      o_block_frames,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sgclm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sgclm_pkg::GAIN_W-1:0]        i_cfg_data
);

    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W  = sgclm_pkg::SQ_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int SW     = sgclm_pkg::SAMPLE_W;
    localparam int PW     = sgclm_pkg::PROD_W;
    localparam int MW     = sgclm_pkg::MAG_W;
    localparam int RW     = sgclm_pkg::ROOT_W;
    localparam int QW     = sgclm_pkg::SQ_W;
    localparam int REM_W  = RW + 3;

    sgclm_pkg::t_state r_state, n_state;

    logic [sgclm_pkg::GAIN_W-1:0] r_gain_first, r_gain_second;
    logic                         r_single, r_mono;

    logic [sgclm_pkg::GAIN_W-1:0] r_gain, n_gain;
    logic [SW-1:0]    r_mag_l, n_mag_l, r_mag_r, n_mag_r;
    logic [PW-1:0]    r_acc_l, n_acc_l, r_acc_r, n_acc_r;
    logic             r_neg_l, n_neg_l, r_neg_r, n_neg_r;
    logic             r_last, n_last;
    logic [STEP_W-1:0] r_step, n_step;

    logic signed [SW-1:0] r_res_l, n_res_l, r_res_r, n_res_r;
    logic [MW-1:0]    r_lvl, n_lvl;
    logic [QW-1:0]    r_sqr_acc, n_sqr_acc;

    logic [MW-1:0]    r_peak, n_peak;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_frame_cnt, n_frame_cnt;

    logic             r_blk_end, n_blk_end;
    logic [MW-1:0]    r_blk_peak, n_blk_peak;
    logic [CNT_W-1:0] r_blk_frames, n_blk_frames;
    logic [SUM_W-1:0] r_div_q, n_div_q;
    logic [CNT_W-1:0] r_div_r, n_div_r;
    logic [QW-1:0]    r_sq_x, n_sq_x;
    logic [REM_W-1:0] r_sq_rem, n_sq_rem;
    logic [RW-1:0]    r_root, n_root;

    logic             r_out_valid, n_out_valid;
    logic signed [SW-1:0] r_out_left, n_out_left, r_out_right, n_out_right;
    logic             r_out_lv, n_out_lv;
    logic [MW-1:0]    r_out_peak, n_out_peak;
    logic [RW-1:0]    r_out_rms, n_out_rms;
    logic [sgclm_pkg::FRAMES_W-1:0] r_out_frames, n_out_frames;

    // combinational helpers
    logic signed [SW-1:0] raw_r;
    logic [MW-1:0]    cl_l, cl_r, lvl_w;
    logic signed [SW-1:0] g_l, g_r;
    logic signed [SW:0]   mix_sum, mix_adj;
    logic [MW-1:0]    peak_upd;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W:0]   div_trial, div_dvs;
    logic [REM_W-1:0] sq_trial, sq_cand;
    logic             out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_first  <= sgclm_pkg::GAIN_RESET;
            r_gain_second <= sgclm_pkg::GAIN_RESET;
            r_single      <= 1'b0;
            r_mono        <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sgclm_pkg::CFG_GAIN_FIRST:  r_gain_first  <= i_cfg_data;
                sgclm_pkg::CFG_GAIN_SECOND: r_gain_second <= i_cfg_data;
                sgclm_pkg::CFG_SINGLE_CH:   r_single      <= i_cfg_data[0];
                sgclm_pkg::CFG_MONO_MIX:    r_mono        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sgclm_pkg::ST_IDLE;
            r_peak      <= '0;
            r_sum       <= '0;
            r_frame_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_peak      <= n_peak;
            r_sum       <= n_sum;
            r_frame_cnt <= n_frame_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gain       <= n_gain;
        r_mag_l      <= n_mag_l;
        r_mag_r      <= n_mag_r;
        r_acc_l      <= n_acc_l;
        r_acc_r      <= n_acc_r;
        r_neg_l      <= n_neg_l;
        r_neg_r      <= n_neg_r;
        r_last       <= n_last;
        r_step       <= n_step;
        r_res_l      <= n_res_l;
        r_res_r      <= n_res_r;
        r_lvl        <= n_lvl;
        r_sqr_acc    <= n_sqr_acc;
        r_blk_end    <= n_blk_end;
        r_blk_peak   <= n_blk_peak;
        r_blk_frames <= n_blk_frames;
        r_div_q      <= n_div_q;
        r_div_r      <= n_div_r;
        r_sq_x       <= n_sq_x;
        r_sq_rem     <= n_sq_rem;
        r_root       <= n_root;
        r_out_left   <= n_out_left;
        r_out_right  <= n_out_right;
        r_out_lv     <= n_out_lv;
        r_out_peak   <= n_out_peak;
        r_out_rms    <= n_out_rms;
        r_out_frames <= n_out_frames;
    end

    always_comb begin
        n_state      = r_state;
        n_gain       = r_gain;
        n_mag_l      = r_mag_l;
        n_mag_r      = r_mag_r;
        n_acc_l      = r_acc_l;
        n_acc_r      = r_acc_r;
        n_neg_l      = r_neg_l;
        n_neg_r      = r_neg_r;
        n_last       = r_last;
        n_step       = r_step;
        n_res_l      = r_res_l;
        n_res_r      = r_res_r;
        n_lvl        = r_lvl;
        n_sqr_acc    = r_sqr_acc;
        n_peak       = r_peak;
        n_sum        = r_sum;
        n_frame_cnt  = r_frame_cnt;
        n_blk_end    = r_blk_end;
        n_blk_peak   = r_blk_peak;
        n_blk_frames = r_blk_frames;
        n_div_q      = r_div_q;
        n_div_r      = r_div_r;
        n_sq_x       = r_sq_x;
        n_sq_rem     = r_sq_rem;
        n_root       = r_root;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_left   = r_out_left;
        n_out_right  = r_out_right;
        n_out_lv     = r_out_lv;
        n_out_peak   = r_out_peak;
        n_out_rms    = r_out_rms;
        n_out_frames = r_out_frames;
        o_in_ready   = 1'b0;

        raw_r    = r_single ? i_left_sample : i_right_sample;
        // product >> 16, saturated to 15-bit magnitude
        cl_l     = (|r_acc_l[PW-1:sgclm_pkg::FRAC_W+MW]) ? sgclm_pkg::SAT_MAX
                                                         : r_acc_l[sgclm_pkg::FRAC_W +: MW];
        cl_r     = (|r_acc_r[PW-1:sgclm_pkg::FRAC_W+MW]) ? sgclm_pkg::SAT_MAX
                                                         : r_acc_r[sgclm_pkg::FRAC_W +: MW];
        g_l      = r_neg_l ? -$signed({1'b0, cl_l}) : $signed({1'b0, cl_l});
        g_r      = r_neg_r ? -$signed({1'b0, cl_r}) : $signed({1'b0, cl_r});
        lvl_w    = (cl_l > cl_r) ? cl_l : cl_r;
        // truncate toward zero: bias negative sums by one before the shift
        mix_sum  = (SW+1)'(g_l) + (SW+1)'(g_r);
        mix_adj  = mix_sum + ((SW+1)'(mix_sum[SW]));
        peak_upd = (r_lvl > r_peak) ? r_lvl : r_peak;
        cnt_inc  = r_frame_cnt + CNT_W'(1);
        div_trial = {r_div_r, r_div_q[SUM_W-1]};
        div_dvs   = {1'b0, r_blk_frames};
        sq_cand   = {r_sq_rem[REM_W-3:0], r_sq_x[QW-1 -: 2]};
        sq_trial  = {1'b0, r_root, 2'b01};
        out_free  = !r_out_valid || i_out_ready;

        unique case (r_state)
            sgclm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_gain  = i_instance_req ? r_gain_second : r_gain_first;
                    n_neg_l = i_left_sample[SW-1];
                    n_neg_r = raw_r[SW-1];
                    n_mag_l = i_left_sample[SW-1] ? $unsigned(-i_left_sample)
                                                  : $unsigned(i_left_sample);
                    n_mag_r = raw_r[SW-1] ? $unsigned(-raw_r) : $unsigned(raw_r);
                    n_acc_l = '0;
                    n_acc_r = '0;
                    n_last  = i_last_frame;
                    n_step  = STEP_W'(SW);
                    n_state = sgclm_pkg::ST_MUL;
                end
            end
            sgclm_pkg::ST_MUL: begin
                // MSB-first shift-and-add, one magnitude bit per cycle
                n_acc_l = {r_acc_l[PW-2:0], 1'b0} + (r_mag_l[SW-1] ? PW'(r_gain) : '0);
                n_acc_r = {r_acc_r[PW-2:0], 1'b0} + (r_mag_r[SW-1] ? PW'(r_gain) : '0);
                n_mag_l = {r_mag_l[SW-2:0], 1'b0};
                n_mag_r = {r_mag_r[SW-2:0], 1'b0};
                n_step  = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    n_state = sgclm_pkg::ST_LVL;
                end
            end
            sgclm_pkg::ST_LVL: begin
                n_res_l   = r_mono ? mix_adj[SW:1] : g_l;
                n_res_r   = r_mono ? mix_adj[SW:1] : g_r;
                n_lvl     = lvl_w;
                n_mag_l   = SW'(lvl_w);
                n_sqr_acc = '0;
                n_step    = STEP_W'(MW);
                n_state   = sgclm_pkg::ST_SQR;
            end
            sgclm_pkg::ST_SQR: begin
                // lvl squared, reusing the left magnitude shifter as the multiplier bits
                n_sqr_acc = {r_sqr_acc[QW-2:0], 1'b0} + (r_mag_l[MW-1] ? QW'(r_lvl) : '0);
                n_mag_l   = {r_mag_l[SW-2:0], 1'b0};
                n_step    = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    n_state = sgclm_pkg::ST_ACC;
                end
            end
            sgclm_pkg::ST_ACC: begin
                n_blk_end = r_last || (cnt_inc == CNT_W'(MAX_FRAMES));
                if (n_blk_end) begin
                    n_blk_peak   = peak_upd;
                    n_blk_frames = cnt_inc;
                    n_div_q      = r_sum + SUM_W'(r_sqr_acc);
                    n_div_r      = '0;
                    n_step       = STEP_W'(SUM_W);
                    n_peak       = '0;
                    n_sum        = '0;
                    n_frame_cnt  = '0;
                    n_state      = sgclm_pkg::ST_DIV;
                end else begin
                    n_peak      = peak_upd;
                    n_sum       = r_sum + SUM_W'(r_sqr_acc);
                    n_frame_cnt = cnt_inc;
                    n_state     = sgclm_pkg::ST_DONE;
                end
            end
            sgclm_pkg::ST_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (div_trial >= div_dvs) begin
                    n_div_r = CNT_W'(div_trial - div_dvs);
                    n_div_q = {r_div_q[SUM_W-2:0], 1'b1};
                end else begin
                    n_div_r = div_trial[CNT_W-1:0];
                    n_div_q = {r_div_q[SUM_W-2:0], 1'b0};
                end
                n_step = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    n_state = sgclm_pkg::ST_SQRT;
                end
            end
            sgclm_pkg::ST_SQRT: begin
                // mean square fits in 30 bits; two radicand bits per cycle
                if (r_step == '0) begin
                    n_sq_x   = r_div_q[QW-1:0];
                    n_sq_rem = '0;
                    n_root   = '0;
                    n_step   = STEP_W'(RW);
                end else begin
                    n_sq_x = {r_sq_x[QW-3:0], 2'b00};
                    if (sq_cand >= sq_trial) begin
                        n_sq_rem = sq_cand - sq_trial;
                        n_root   = {r_root[RW-2:0], 1'b1};
                    end else begin
                        n_sq_rem = sq_cand;
                        n_root   = {r_root[RW-2:0], 1'b0};
                    end
                    n_step = r_step - STEP_W'(1);
                    if (r_step == STEP_W'(1)) begin
                        n_state = sgclm_pkg::ST_DONE;
                    end
                end
            end
            sgclm_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_left   = r_res_l;
                    n_out_right  = r_res_r;
                    n_out_lv     = r_blk_end;
                    n_out_peak   = r_blk_end ? r_blk_peak : '0;
                    n_out_rms    = r_blk_end ? r_root : '0;
                    n_out_frames = r_blk_end ? sgclm_pkg::FRAMES_W'(r_blk_frames) : '0;
                    n_state      = sgclm_pkg::ST_IDLE;
                end
            end
            default: n_state = sgclm_pkg::ST_IDLE;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_left     = r_out_left;
    assign o_out_right    = r_out_right;
    assign o_level_valid  = r_out_lv;
    assign o_peak_level   = r_out_peak;
    assign o_rms_level    = r_out_rms;
    assign o_block_frames = r_out_frames;

    `SGCLM_ASSERT_NEXT(a_accept_starts_mul, i_in_valid && o_in_ready,
        r_state == sgclm_pkg::ST_MUL, "accepted frame did not start the multiply")
    `SGCLM_ASSERT_SAME(a_cnt_below_max, 1'b1,
        r_frame_cnt < CNT_W'(MAX_FRAMES), "frame counter reached block limit at rest")
    `SGCLM_ASSERT_SAME(a_levels_zero, o_out_valid && !o_level_valid,
        (o_peak_level == '0) && (o_rms_level == '0) && (o_block_frames == '0),
        "level fields nonzero on a non-final frame")
    `SGCLM_ASSERT_SAME(a_rms_le_peak, (r_state == sgclm_pkg::ST_DONE) && r_blk_end,
        r_root <= r_blk_peak, "rms level above block peak")

endmodule
